@@ rtl/core/spd_pkg.sv @@
// ----------------------------------------------------------------------------
// spd_pkg
// Shared types, constants and arithmetic helpers of the ping-pong delay core.
// ----------------------------------------------------------------------------
package spd_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int MAX_DELAY   = 262144;          // power of two, line depth
  localparam int ADDR_W      = $clog2(MAX_DELAY);
  localparam int DELAY_W     = 19;
  localparam int PCT_W       = 7;
  localparam int GAIN_W      = 17;              // unsigned Q1.16, up to 1.0
  localparam int PROD_W      = SAMPLE_BITS + GAIN_W + 1;
  localparam int RND_W       = PROD_W - 16;
  localparam int SUM_W       = RND_W + 1;
  localparam int CFG_AW      = 3;
  localparam int CFG_DW      = DELAY_W;
  localparam int TDATA_W     = 2 * SAMPLE_BITS;

  localparam logic [GAIN_W-1:0] UNITY = GAIN_W'(65536);

  // floor(x / 100) as (x * RECIP) >> RECIP_SH, exact for x below 2^23
  localparam logic [23:0] RECIP    = 24'd10737419;
  localparam int          RECIP_SH = 30;

  // register indexes
  localparam logic [CFG_AW-1:0] CFG_DELAY    = CFG_AW'(0);
  localparam logic [CFG_AW-1:0] CFG_FEEDBACK = CFG_AW'(1);
  localparam logic [CFG_AW-1:0] CFG_SPATIAL  = CFG_AW'(2);
  localparam logic [CFG_AW-1:0] CFG_MIX      = CFG_AW'(3);
  localparam logic [CFG_AW-1:0] CFG_INVERT   = CFG_AW'(4);

  // reset values
  localparam logic [DELAY_W-1:0] RST_DELAY = DELAY_W'(8820);
  localparam logic [PCT_W-1:0]   RST_PCT   = PCT_W'(50);

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic [GAIN_W-1:0]             gain_t;
  typedef logic [ADDR_W-1:0]             addr_t;
  typedef logic signed [PROD_W-1:0]      prod_t;

  typedef struct packed {
    logic  acc;      // request accepted, launch line read
    addr_t rd_addr;
    logic  byp_hit;  // read slot is the one written this edge
    logic  rd_ok;    // read slot has been written since reset
    logic  s2_ld;
    logic  wr_en;
    addr_t wr_addr;
  } lane_ctrl_t;

  // percent to Q1.16 gain: (p*65536 + 50) / 100, percent clamped to 100
  function automatic gain_t pct_gain(input logic [PCT_W-1:0] p);
    logic [PCT_W-1:0] pc;
    logic [22:0]      x;
    logic [47:0]      prod;
    pc   = (p > PCT_W'(100)) ? PCT_W'(100) : p;
    x    = {pc, 16'd0} + 23'd50;
    prod = 48'(x) * 48'(RECIP);
    return prod[RECIP_SH+GAIN_W-1:RECIP_SH];
  endfunction

  // round half up, back to integer scale
  function automatic logic signed [RND_W-1:0] rnd_q16(input prod_t p);
    prod_t t;
    t = p + PROD_W'(32768);
    return t[PROD_W-1:16];
  endfunction

  function automatic sample_t sat_add(input logic signed [RND_W-1:0] a,
                                      input logic signed [RND_W-1:0] b);
    logic signed [SUM_W-1:0] s;
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    s  = SUM_W'(a) + SUM_W'(b);
    hi = SUM_W'({1'b0, {(SAMPLE_BITS-1){1'b1}}});
    lo = -hi - SUM_W'(1);
    if (s > hi) begin
      return hi[SAMPLE_BITS-1:0];
    end else if (s < lo) begin
      return lo[SAMPLE_BITS-1:0];
    end
    return s[SAMPLE_BITS-1:0];
  endfunction

endpackage

@@ rtl/core/stereo_ping_pong_delay_core.sv @@
// ----------------------------------------------------------------------------
// stereo_ping_pong_delay_core
// Stereo ping-pong delay with cross feedback and dry/wet mix.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one stereo sample pair per request, left in tdata[23:0].
//   out_* : one mixed pair per input request, same packing.
//   cfg_* : register writes (0 delay, 1 feedback, 2 spatial, 3 mix,
//           4 invert side), only while no request is in flight.
// Timing:
//   A request accepted on in_* waits in stage 1 for its line RAM read, its
//   products are registered in stage 2 and the mixed pair then drives out_*
//   from the output register. A new request is taken only once the last has
//   left stage 1: the line RAM read launched at acceptance must come back and
//   the resulting feed be written before the next read, so the loop through
//   the shared write pointer sets the pace. Both channels run in parallel lanes.
// Reset:
//   Registers take their defaults, the write pointer returns to zero and
//   the delay lines read as silence until overwritten; no clearing pass.
// Stall:
//   out_* holds a result while out_tready is low; two more requests can
//   sit in the pipe behind it, then in_tready drops.
// ----------------------------------------------------------------------------
module stereo_ping_pong_delay_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [spd_pkg::TDATA_W-1:0]  in_tdata,   // in_left, in_right
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [spd_pkg::TDATA_W-1:0]  out_tdata,  // out_left, out_right
  input  logic                         cfg_wr_en,
  input  logic [spd_pkg::CFG_AW-1:0]   cfg_addr,
  input  logic [spd_pkg::CFG_DW-1:0]   cfg_wdata
);

  localparam int SB = spd_pkg::SAMPLE_BITS;

  // configuration
  logic [spd_pkg::DELAY_W-1:0] delay_r;
  logic [spd_pkg::PCT_W-1:0]   fb_pct_r;
  logic [spd_pkg::PCT_W-1:0]   sp_pct_r;
  logic [spd_pkg::PCT_W-1:0]   mix_pct_r;
  logic                        inv_r;

  spd_pkg::gain_t g_fb_r;
  spd_pkg::gain_t g_l_r;
  spd_pkg::gain_t g_r_r;
  spd_pkg::gain_t g_wet_r;
  spd_pkg::gain_t g_dry_r;
  spd_pkg::gain_t att;
  spd_pkg::gain_t wet;

  // pipeline control
  spd_pkg::addr_t wp_r, wp_nxt;
  logic           wrapped_r, wrapped_nxt;
  spd_pkg::addr_t s1_wp_r;
  spd_pkg::addr_t s2_wp_r;
  logic           s1_valid_r, s1_valid_nxt;
  logic           s2_valid_r, s2_valid_nxt;
  logic           out_valid_r, out_valid_nxt;
  spd_pkg::sample_t out_l_r;
  spd_pkg::sample_t out_r_r;

  logic                        adv;
  logic                        s2_free;
  logic                        acc;
  logic [spd_pkg::DELAY_W-1:0] d_clip;
  spd_pkg::addr_t              d_eff;
  spd_pkg::addr_t              rd_addr;
  spd_pkg::lane_ctrl_t         ctrl;

  spd_pkg::sample_t d_l, d_r, feed_l, feed_r, y_l, y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_r   <= spd_pkg::RST_DELAY;
      fb_pct_r  <= spd_pkg::RST_PCT;
      sp_pct_r  <= spd_pkg::RST_PCT;
      mix_pct_r <= spd_pkg::RST_PCT;
      inv_r     <= 1'b0;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        spd_pkg::CFG_DELAY:    delay_r   <= cfg_wdata;
        spd_pkg::CFG_FEEDBACK: fb_pct_r  <= cfg_wdata[spd_pkg::PCT_W-1:0];
        spd_pkg::CFG_SPATIAL:  sp_pct_r  <= cfg_wdata[spd_pkg::PCT_W-1:0];
        spd_pkg::CFG_MIX:      mix_pct_r <= cfg_wdata[spd_pkg::PCT_W-1:0];
        spd_pkg::CFG_INVERT:   inv_r     <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // gains are registered from the settings and settle after a write, before any product uses them
  assign att = spd_pkg::UNITY - spd_pkg::pct_gain(sp_pct_r);
  assign wet = spd_pkg::pct_gain(mix_pct_r);

  always_ff @(posedge clk) begin
    g_fb_r  <= spd_pkg::pct_gain(fb_pct_r);
    g_l_r   <= inv_r ? att : spd_pkg::UNITY;
    g_r_r   <= inv_r ? spd_pkg::UNITY : att;
    g_wet_r <= wet;
    g_dry_r <= spd_pkg::UNITY - wet;
  end

  // delay clamped to 1..MAX_DELAY; MAX_DELAY wraps onto the write slot
  assign d_clip  = (delay_r > spd_pkg::DELAY_W'(spd_pkg::MAX_DELAY)) ?
                   spd_pkg::DELAY_W'(spd_pkg::MAX_DELAY) : delay_r;
  assign d_eff   = (delay_r == '0) ? spd_pkg::ADDR_W'(1) : d_clip[spd_pkg::ADDR_W-1:0];
  assign rd_addr = wp_r - d_eff;

  // output stage loads when empty or drained; stage 2 moves when free
  assign adv       = !out_valid_r || out_tready;
  assign s2_free   = !s2_valid_r || adv;
  assign in_tready = !s1_valid_r;
  assign acc       = in_tvalid && in_tready;

  always_comb begin
    ctrl.acc     = acc;
    ctrl.rd_addr = rd_addr;
    ctrl.byp_hit = s2_valid_r && (s2_wp_r == rd_addr);
    ctrl.rd_ok   = wrapped_r || (rd_addr < wp_r);
    ctrl.s2_ld   = s2_free && s1_valid_r;
    ctrl.wr_en   = s2_valid_r;
    ctrl.wr_addr = s2_wp_r;
  end

  always_comb begin
    wp_nxt        = acc ? wp_r + spd_pkg::ADDR_W'(1) : wp_r;
    wrapped_nxt   = wrapped_r || (acc && (wp_r == '1));
    s1_valid_nxt  = acc || (s1_valid_r && !s2_free);
    s2_valid_nxt  = s2_free ? s1_valid_r : s2_valid_r;
    out_valid_nxt = adv ? s2_valid_r : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r        <= '0;
      wrapped_r   <= 1'b0;
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      wp_r        <= wp_nxt;
      wrapped_r   <= wrapped_nxt;
      s1_valid_r  <= s1_valid_nxt;
      s2_valid_r  <= s2_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_wp_r <= wp_r;
    end
    if (ctrl.s2_ld) begin
      s2_wp_r <= s1_wp_r;
    end
    if (adv && s2_valid_r) begin
      out_l_r <= y_l;
      out_r_r <= y_r;
    end
  end

  spd_lane u_lane_l (
    .clk    (clk),
    .ctrl   (ctrl),
    .x_in   ($signed(in_tdata[SB-1:0])),
    .g_in   (g_l_r),
    .g_fb   (g_fb_r),
    .g_dry  (g_dry_r),
    .g_wet  (g_wet_r),
    .d_other(d_r),
    .d_own  (d_l),
    .feed   (feed_l),
    .y      (y_l)
  );

  spd_lane u_lane_r (
    .clk    (clk),
    .ctrl   (ctrl),
    .x_in   ($signed(in_tdata[2*SB-1:SB])),
    .g_in   (g_r_r),
    .g_fb   (g_fb_r),
    .g_dry  (g_dry_r),
    .g_wet  (g_wet_r),
    .d_other(d_l),
    .d_own  (d_r),
    .feed   (feed_r),
    .y      (y_r)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_r_r, out_l_r};

endmodule

@@ rtl/core/spd_ram.sv @@
// ----------------------------------------------------------------------------
// spd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module spd_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/core/spd_lane.sv @@
// ----------------------------------------------------------------------------
// spd_lane
// One channel: delay line, delayed-sample select, gain products, feed and mix.
// ----------------------------------------------------------------------------
module spd_lane (
  input  logic                clk,
  input  spd_pkg::lane_ctrl_t ctrl,
  input  spd_pkg::sample_t    x_in,
  input  spd_pkg::gain_t      g_in,
  input  spd_pkg::gain_t      g_fb,
  input  spd_pkg::gain_t      g_dry,
  input  spd_pkg::gain_t      g_wet,
  input  spd_pkg::sample_t    d_other,
  output spd_pkg::sample_t    d_own,
  output spd_pkg::sample_t    feed,
  output spd_pkg::sample_t    y
);

  spd_pkg::sample_t x_s1_r;
  spd_pkg::sample_t byp_r;
  logic             hit_r;
  logic             ok_r;
  logic [spd_pkg::SAMPLE_BITS-1:0] ram_q;

  spd_pkg::prod_t p_in_r;
  spd_pkg::prod_t p_fb_r;
  spd_pkg::prod_t p_dry_r;
  spd_pkg::prod_t p_wet_r;

  spd_ram #(
    .WIDTH(spd_pkg::SAMPLE_BITS),
    .DEPTH(spd_pkg::MAX_DELAY)
  ) u_line (
    .clk  (clk),
    .we   (ctrl.wr_en),
    .waddr(ctrl.wr_addr),
    .wdata(feed),
    .re   (ctrl.acc),
    .raddr(ctrl.rd_addr),
    .rdata(ram_q)
  );

  always_ff @(posedge clk) begin
    if (ctrl.acc) begin
      x_s1_r <= x_in;
      byp_r  <= feed;
      hit_r  <= ctrl.byp_hit;
      ok_r   <= ctrl.rd_ok;
    end
  end

  // slots never written since reset read as silence
  always_comb begin
    if (hit_r) begin
      d_own = byp_r;
    end else if (ok_r) begin
      d_own = $signed(ram_q);
    end else begin
      d_own = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.s2_ld) begin
      p_in_r  <= x_s1_r  * $signed({1'b0, g_in});
      p_fb_r  <= d_other * $signed({1'b0, g_fb});
      p_dry_r <= x_s1_r  * $signed({1'b0, g_dry});
      p_wet_r <= d_own   * $signed({1'b0, g_wet});
    end
  end

  assign feed = spd_pkg::sat_add(spd_pkg::rnd_q16(p_in_r), spd_pkg::rnd_q16(p_fb_r));
  assign y    = spd_pkg::sat_add(spd_pkg::rnd_q16(p_dry_r), spd_pkg::rnd_q16(p_wet_r));

endmodule

@@ rtl/core/spd_checker.sv @@
// ----------------------------------------------------------------------------
// spd_checker
// Port-level checks of the ping-pong delay core, bound to the top level.
// ----------------------------------------------------------------------------
module spd_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_tvalid,
  input logic                        in_tready,
  input logic                        out_tvalid,
  input logic                        out_tready,
  input logic [spd_pkg::TDATA_W-1:0] out_tdata
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output changed while stalled");

  // no back-to-back request accepts
  a_in_spacing: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("back-to-back input accept");

  a_rst_clear: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  // with the receiver ready after acceptance, a valid result follows
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) ##1 out_tready ##1 out_tready |=> out_tvalid)
    else $error("result missing after accepted request");

endmodule

bind stereo_ping_pong_delay_core spd_checker u_spd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tvalid (in_tvalid),
  .in_tready (in_tready),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata)
);

@@ dv/tb_stereo_ping_pong_delay_core.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_stereo_ping_pong_delay_core
// Self-checking bench for the ping-pong delay core. A directed table hits
// the sample extremes and the odd register values: percent above 100, zero
// delay, delay past the line depth, and writes to unused register indexes.
// Random phases with fresh register settings follow. Every accepted request
// runs through a local model of both delay lines. Each result is compared
// with the oldest pending expectation.
// ----------------------------------------------------------------------------
module tb_stereo_ping_pong_delay_core;

  localparam int CFG_AW      = spd_pkg::CFG_AW;
  localparam int CFG_DW      = spd_pkg::CFG_DW;
  localparam int TDATA_W     = spd_pkg::TDATA_W;
  localparam int SAMPLE_BITS = spd_pkg::SAMPLE_BITS;
  localparam int MAX_DELAY   = spd_pkg::MAX_DELAY;

  localparam logic [CFG_AW-1:0] CFG_DELAY    = spd_pkg::CFG_DELAY;
  localparam logic [CFG_AW-1:0] CFG_FEEDBACK = spd_pkg::CFG_FEEDBACK;
  localparam logic [CFG_AW-1:0] CFG_SPATIAL  = spd_pkg::CFG_SPATIAL;
  localparam logic [CFG_AW-1:0] CFG_MIX      = spd_pkg::CFG_MIX;
  localparam logic [CFG_AW-1:0] CFG_INVERT   = spd_pkg::CFG_INVERT;

  typedef spd_pkg::sample_t sample_t;

  localparam logic [CFG_AW-1:0] CFG_SPARE = CFG_AW'(5);   // no register here
  localparam logic [CFG_AW-1:0] CFG_TOP   = CFG_AW'(7);   // no register here
  localparam int SMAX         = 8388607;
  localparam int SMIN         = -8388608;
  localparam int PHASES       = 6;
  localparam int PHASE_PAIRS  = 75;
  localparam int PRESSURE_AT  = 300;
  localparam int HOLD_CYCLES  = 80;
  localparam int PLAN_ROWS    = 43;

  typedef struct packed {
    sample_t l;
    sample_t r;
  } mix_pair_t;

  typedef enum logic [1:0] {ROW_PAIR, ROW_PAIR_CHK, ROW_WRITE} row_kind_t;

  typedef struct {
    row_kind_t         kind;
    logic [CFG_AW-1:0] idx;
    int unsigned       val;
    int                l;
    int                r;
    int                el;   // typed expectation, ROW_PAIR_CHK only
    int                er;
  } plan_row_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [TDATA_W-1:0]   in_tdata;
  logic                 out_tvalid;
  logic                 out_tready;
  logic [TDATA_W-1:0]   out_tdata;
  logic                 cfg_wr_en;
  logic [CFG_AW-1:0]    cfg_addr;
  logic [CFG_DW-1:0]    cfg_wdata;

  // model state
  int          echo_left  [MAX_DELAY];
  int          echo_right [MAX_DELAY];
  int unsigned wr_pos;
  int unsigned dly_reg;
  int unsigned fb_reg;
  int unsigned sp_reg;
  int unsigned mix_reg;
  int unsigned inv_reg;

  mix_pair_t pending_mix [$];
  int        mix_errors;
  int        items_taken;
  bit        calm;
  bit        pressure_done;

  stereo_ping_pong_delay_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),     // in_left, in_right
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),    // out_left, out_right
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic longint pct_to_gain(input int unsigned p);
    if (p > 100) begin
      p = 100;
    end
    return longint'((p * 65536 + 50) / 100);
  endfunction

  // Q1.16 product, halves round up (arithmetic shift floors)
  function automatic longint scale(input longint x, input longint g);
    return (x * g + 32768) >>> 16;
  endfunction

  function automatic int clip(input longint v);
    if (v > SMAX) begin
      return SMAX;
    end else if (v < SMIN) begin
      return SMIN;
    end
    return int'(v);
  endfunction

  task automatic echo_step(input sample_t xl, input sample_t xr, output mix_pair_t res);
    int unsigned d;
    int unsigned rd;
    longint      dl, dr, fb, att, gl, gr, wet, dry;
    d = (dly_reg == 0) ? 1 : ((dly_reg > MAX_DELAY) ? MAX_DELAY : dly_reg);
    rd = (wr_pos >= d) ? (wr_pos - d) : (wr_pos + MAX_DELAY - d);
    dl = echo_left[rd];
    dr = echo_right[rd];
    fb = pct_to_gain(fb_reg);
    att = 65536 - pct_to_gain(sp_reg);
    gl = inv_reg ? att : 65536;
    gr = inv_reg ? 65536 : att;
    // cross feedback: each line takes the other side's tap
    echo_left[wr_pos] = clip(scale(longint'(xl), gl) + scale(dr, fb));
    echo_right[wr_pos] = clip(scale(longint'(xr), gr) + scale(dl, fb));
    wr_pos = (wr_pos + 1) % MAX_DELAY;
    wet = pct_to_gain(mix_reg);
    dry = 65536 - wet;
    res.l = sample_t'(clip(scale(longint'(xl), dry) + scale(dl, wet)));
    res.r = sample_t'(clip(scale(longint'(xr), dry) + scale(dr, wet)));
  endtask

  function automatic int pick_gap();
    int n;
    n = 0;
    if (calm) begin
      return 0;
    end
    while ($urandom_range(99) < 32 && n < 12) begin
      n++;
    end
    return n;
  endfunction

  function automatic sample_t pick_sample();
    case ($urandom_range(9))
      0: return sample_t'(SMAX);
      1: return sample_t'(SMIN);
      2: return '0;
      3: return sample_t'(int'($urandom_range(0, 512)) - 256);
      default: return sample_t'($urandom);
    endcase
  endfunction

  function automatic int unsigned pick_delay();
    case ($urandom_range(9))
      0: return 0;
      1: return MAX_DELAY;
      2: return $urandom_range(0, 19'h7FFFF);
      default: return $urandom_range(1, 48);
    endcase
  endfunction

  function automatic int unsigned pick_pct();
    int unsigned p;
    p = ($urandom_range(4) == 0) ? $urandom_range(101, 127) : $urandom_range(0, 100);
    // stray upper bits must be dropped by the register
    if ($urandom_range(3) == 0) begin
      p = p | ($urandom & 32'h7FF80);
    end
    return p;
  endfunction

  task automatic write_reg(input logic [CFG_AW-1:0] idx, input int unsigned val);
    @(negedge clk);
    in_tvalid = 1'b0;
    while (pending_mix.size() != 0) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
    @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_addr  = idx;
    cfg_wdata = CFG_DW'(val);
    @(negedge clk);
    cfg_wr_en = 1'b0;
    case (idx)
      CFG_DELAY:    dly_reg = val & 32'h7FFFF;
      CFG_FEEDBACK: fb_reg  = val & 32'h7F;
      CFG_SPATIAL:  sp_reg  = val & 32'h7F;
      CFG_MIX:      mix_reg = val & 32'h7F;
      CFG_INVERT:   inv_reg = val & 32'h1;
      default: ;
    endcase
  endtask

  task automatic push_pair(input sample_t l, input sample_t r, input bit typed,
                           input sample_t tl, input sample_t tr);
    mix_pair_t calc;
    int        gap;
    gap = pick_gap();
    repeat (gap) begin
      @(negedge clk);
      in_tvalid = 1'b0;
    end
    @(negedge clk);
    in_tvalid = 1'b1;
    in_tdata  = {r, l};
    do @(posedge clk); while (!in_tready);
    echo_step(l, r, calc);
    if (typed) begin
      calc.l = tl;
      calc.r = tr;
    end
    pending_mix.push_back(calc);
    items_taken++;
  endtask

  // result side: random stalls, one long hold-off so the input backs up
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (!pressure_done && items_taken >= PRESSURE_AT) begin
        out_tready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        pressure_done = 1'b1;
      end
      out_tready = calm || ($urandom_range(99) >= 32);
    end
  end

  always @(posedge clk) begin : mix_check
    mix_pair_t want;
    sample_t   got_l;
    sample_t   got_r;
    if (rst_n && out_tvalid && out_tready) begin
      got_l = out_tdata[SAMPLE_BITS-1:0];
      got_r = out_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
      if (pending_mix.size() == 0) begin
        mix_errors++;
        $display("%0t: unexpected result left %0d right %0d", $time, got_l, got_r);
      end else begin
        want = pending_mix.pop_front();
        if (got_l !== want.l) begin
          mix_errors++;
          $display("%0t: out_left expected %0d got %0d", $time, want.l, got_l);
        end
        if (got_r !== want.r) begin
          mix_errors++;
          $display("%0t: out_right expected %0d got %0d", $time, want.r, got_r);
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("FAIL stereo_ping_pong_delay_core");
    $finish;
  end

  initial begin
    plan_row_t plan [PLAN_ROWS];
    plan = '{
      // reset settings: lines read silent, 50/50 mix halves the input
      '{ROW_PAIR_CHK, CFG_DELAY, 0, 0, 0, 0, 0},
      '{ROW_PAIR_CHK, CFG_DELAY, 0, SMAX, SMIN, 4194304, -4194304},
      '{ROW_PAIR_CHK, CFG_DELAY, 0, SMIN, SMAX, -4194304, 4194304},
      '{ROW_PAIR_CHK, CFG_DELAY, 0, 1, -1, 1, 0},
      // shortest delay, full feedback, all wet: saturating echoes
      '{ROW_WRITE, CFG_DELAY, 1, 0, 0, 0, 0},
      '{ROW_WRITE, CFG_FEEDBACK, 100, 0, 0, 0, 0},
      '{ROW_WRITE, CFG_SPATIAL, 0, 0, 0, 0, 0},
      '{ROW_WRITE, CFG_MIX, 100, 0, 0, 0, 0},
      '{ROW_PAIR, CFG_DELAY, 0, SMAX, SMAX, 0, 0},
      '{ROW_PAIR, CFG_DELAY, 0, SMAX, SMAX, 0, 0},
      '{ROW_PAIR, CFG_DELAY, 0, SMIN, SMIN, 0, 0},
      '{ROW_PAIR, CFG_DELAY, 0, SMIN, SMAX, 0, 0},
      '{ROW_PAIR, CFG_DELAY, 0, 0, 0, 0, 0},
      // all dry: output equals input
      '{ROW_WRITE, CFG_MIX, 0, 0, 0, 0, 0},
      '{ROW_WRITE, CFG_SPATIAL, 100, 0, 0, 0, 0},
      '{ROW_WRITE, CFG_INVERT, 1, 0, 0, 0, 0},
      '{ROW_PAIR_CHK, CFG_DELAY, 0, 123456, -654321, 123456, -654321},
      '{ROW_PAIR_CHK, CFG_DELAY, 0, SMIN, SMAX, SMIN, SMAX},
      // percents above 100, zero delay
      '{ROW_WRITE, CFG_FEEDBACK, 127, 0, 0, 0, 0},
      '{ROW_WRITE, CFG_SPATIAL, 127, 0, 0, 0, 0},
      '{ROW_WRITE, CFG_MIX, 127, 0, 0, 0, 0},
      '{ROW_WRITE, CFG_DELAY, 0, 0, 0, 0, 0},
      '{ROW_PAIR, CFG_DELAY, 0, 5000000, -7000000, 0, 0},
      '{ROW_PAIR, CFG_DELAY, 0, -1, 1, 0, 0},
      '{ROW_PAIR, CFG_DELAY, 0, SMAX, SMIN, 0, 0},
      // delay past the line depth, then exactly the depth
      '{ROW_WRITE, CFG_DELAY, 32'h7FFFF, 0, 0, 0, 0},
      '{ROW_WRITE, CFG_MIX, 50, 0, 0, 0, 0},
      '{ROW_WRITE, CFG_INVERT, 0, 0, 0, 0, 0},
      '{ROW_PAIR, CFG_DELAY, 0, 4321, -4321, 0, 0},
      '{ROW_PAIR, CFG_DELAY, 0, SMAX, SMAX, 0, 0},
      '{ROW_WRITE, CFG_DELAY, MAX_DELAY, 0, 0, 0, 0},
      '{ROW_PAIR, CFG_DELAY, 0, -2, 3, 0, 0},
      // unused indexes must not disturb anything
      '{ROW_WRITE, CFG_SPARE, 32'h7FFFF, 0, 0, 0, 0},
      '{ROW_WRITE, CFG_TOP, 0, 0, 0, 0, 0},
      '{ROW_PAIR, CFG_DELAY, 0, 777, -777, 0, 0},
      '{ROW_WRITE, CFG_DELAY, 2, 0, 0, 0, 0},
      '{ROW_WRITE, CFG_FEEDBACK, 37, 0, 0, 0, 0},
      '{ROW_WRITE, CFG_SPATIAL, 73, 0, 0, 0, 0},
      '{ROW_WRITE, CFG_MIX, 61, 0, 0, 0, 0},
      '{ROW_PAIR, CFG_DELAY, 0, 8191, -3, 0, 0},
      '{ROW_PAIR, CFG_DELAY, 0, SMIN, 65535, 0, 0},
      '{ROW_PAIR, CFG_DELAY, 0, 2097152, -2097153, 0, 0},
      '{ROW_PAIR, CFG_DELAY, 0, 3, SMIN, 0, 0}
    };

    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    cfg_wr_en = 1'b0;
    cfg_addr  = '0;
    cfg_wdata = '0;
    wr_pos    = 0;
    dly_reg   = 8820;
    fb_reg    = 50;
    sp_reg    = 50;
    mix_reg   = 50;
    inv_reg   = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_WRITE) begin
        write_reg(plan[i].idx, plan[i].val);
      end else begin
        push_pair(sample_t'(plan[i].l), sample_t'(plan[i].r), plan[i].kind == ROW_PAIR_CHK,
                  sample_t'(plan[i].el), sample_t'(plan[i].er));
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      calm = (ph == 2);
      write_reg(CFG_DELAY, pick_delay());
      write_reg(CFG_FEEDBACK, pick_pct());
      write_reg(CFG_SPATIAL, pick_pct());
      write_reg(CFG_MIX, pick_pct());
      write_reg(CFG_INVERT, $urandom_range(1));
      repeat (PHASE_PAIRS) begin
        push_pair(pick_sample(), pick_sample(), 1'b0, '0, '0);
      end
    end
    calm = 1'b0;

    @(negedge clk);
    in_tvalid = 1'b0;
    while (pending_mix.size() != 0) begin
      @(posedge clk);
    end
    repeat (8) @(posedge clk);
    if (mix_errors == 0) begin
      $display("PASS stereo_ping_pong_delay_core");
    end else begin
      $display("FAIL stereo_ping_pong_delay_core");
    end
    $finish;
  end

endmodule
